FILE: sv/bqn_pkg.sv
// Shared types, constants and the microprogram of the biquad notch filter core.
`timescale 1ns / 1ps
`default_nettype none

package bqn_pkg;

   localparam int SAMPLE_BITS_DEF    = 16;
   localparam int COEF_FRAC_BITS_DEF = 14;

   localparam int COS_W      = 16;
   localparam int POLE_W     = 15;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_NOTCH_COS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_POLE_D    = CSR_IDX_W'(1);

   localparam logic signed [COS_W-1:0] NOTCH_COS_RST = 16'sd15137;
   localparam logic [POLE_W-1:0]       POLE_D_RST    = 15'd30290;

   localparam int STEP_W     = 3;
   localparam int PROG_STEPS = 8;

   typedef enum logic [1:0] {
      MA_OPD,
      MA_GAIN,
      MA_A1,
      MA_A2
   } mul_a_type;

   typedef enum logic [2:0] {
      MB_COS,
      MB_X0,
      MB_X1,
      MB_X2,
      MB_Y1,
      MB_Y2
   } mul_b_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_SUB
   } acc_op_type;

   typedef struct packed {
      mul_a_type  mul_a;
      mul_b_type  mul_b;
      acc_op_type acc_op;
      logic       load_a1;
      logic       wait_req;
      logic       finish;
   } ctrl_type;

   function automatic ctrl_type bqn_ucode(input logic [STEP_W-1:0] step);
      ctrl_type cw;
      cw = '{mul_a: MA_OPD, mul_b: MB_COS, acc_op: ACC_HOLD,
             load_a1: 1'b0, wait_req: 1'b0, finish: 1'b0};
      case (step)
         3'd0: begin
            cw.wait_req = 1'b1;
         end
         3'd1: begin
            cw.mul_a   = MA_GAIN;
            cw.mul_b   = MB_X0;
            cw.load_a1 = 1'b1;
         end
         3'd2: begin
            cw.mul_a  = MA_A1;
            cw.mul_b  = MB_X1;
            cw.acc_op = ACC_LOAD;
         end
         3'd3: begin
            cw.mul_a  = MA_GAIN;
            cw.mul_b  = MB_X2;
            cw.acc_op = ACC_ADD;
         end
         3'd4: begin
            cw.mul_a  = MA_A1;
            cw.mul_b  = MB_Y1;
            cw.acc_op = ACC_ADD;
         end
         3'd5: begin
            cw.mul_a  = MA_A2;
            cw.mul_b  = MB_Y2;
            cw.acc_op = ACC_SUB;
         end
         3'd6: begin
            cw.acc_op = ACC_SUB;
         end
         3'd7: begin
            cw.finish = 1'b1;
         end
         default: begin
            cw.finish = 1'b1;
         end
      endcase
      return cw;
   endfunction

endpackage

`default_nettype wire

FILE: sv/biquad_notch_filter_core.sv
// Top level of the biquad notch filter core: microcoded sequencer around one multiplier.
`timescale 1ns / 1ps
`default_nettype none

// One sample in, one notch-filtered sample out. For each request an
// eight-step microprogram drives a single shared multiplier that first forms the a1/b1
// coefficient from the cosine and pole registers, then the five biquad products, which are
// summed in an accumulator, rounded and saturated. A new request is taken only at step 0;
// the result register lets the previous result wait while the next request runs, and the
// sequencer holds at its last step while an earlier result is still not taken.
// Write configuration only while the core is idle.
module biquad_notch_filter_core #(
   parameter int SAMPLE_BITS    = bqn_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = bqn_pkg::COEF_FRAC_BITS_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_wr_en,
   input  wire  [bqn_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire  [bqn_pkg::CSR_DATA_W-1:0]        csr_wr_data,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  signed [SAMPLE_BITS-1:0]         req_sample_in,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]         rsp_sample_out
);

   localparam int S      = SAMPLE_BITS;
   localparam int F      = COEF_FRAC_BITS;
   localparam int COEF_W = F + 4;
   localparam int MA_W   = (COEF_W > 17) ? COEF_W : 17;
   localparam int MB_W   = (S > bqn_pkg::COS_W) ? S : bqn_pkg::COS_W;
   localparam int PW     = MA_W + MB_W;
   localparam int ACC_W  = PW + 3;
   localparam int GW     = COEF_W + 17;

   localparam int G_RS  = (16 > F) ? 16 - F : 0;
   localparam int G_LS  = (F > 16) ? F - 16 : 0;
   localparam int G_RND = (1 << G_RS) >> 1;
   localparam int D_RS  = (15 > F) ? 15 - F : 0;
   localparam int D_LS  = (F > 15) ? F - 15 : 0;
   localparam int D_RND = (1 << D_RS) >> 1;
   localparam int A1_RS = 29 - F;

   localparam logic signed [PW:0]    A1_RND = (PW+1)'(1) << (A1_RS - 1);
   localparam logic signed [ACC_W:0] Y_RND  = (ACC_W+1)'(1) << (F - 1);
   localparam logic signed [ACC_W:0] Y_MAX  = {{(ACC_W+2-S){1'b0}}, {(S-1){1'b1}}};
   localparam logic signed [ACC_W:0] Y_MIN  = {{(ACC_W+2-S){1'b1}}, {(S-1){1'b0}}};

   logic signed [bqn_pkg::COS_W-1:0]  cos_ff, cos_in;
   logic        [bqn_pkg::POLE_W-1:0] pole_ff, pole_in;
   logic        [bqn_pkg::STEP_W-1:0] step_ff, step_in;
   logic signed [S-1:0]               x0_ff, x0_in, x1_ff, x1_in, x2_ff, x2_in;
   logic signed [S-1:0]               y1_ff, y1_in, y2_ff, y2_in;
   logic signed [COEF_W-1:0]          a1_ff, a1_in;
   logic signed [PW-1:0]              prod_ff, prod_in;
   logic signed [ACC_W-1:0]           acc_ff, acc_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [S-1:0]               rsp_out_ff, rsp_out_in;

   bqn_pkg::ctrl_type     cw;
   logic                  req_accept;
   logic                  finish_go;
   logic [15:0]           opd;
   logic [GW-1:0]         gain_wide, a2_wide;
   logic signed [COEF_W-1:0] gain, a2;
   logic signed [MA_W-1:0]   mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [PW:0]       a1_sum;
   logic signed [PW:0]       a1_shift;
   logic signed [ACC_W:0]    y_sum;
   logic signed [ACC_W:0]    y_full;
   logic signed [S-1:0]      y_sat;

   assign cw         = bqn_pkg::bqn_ucode(step_ff);
   assign req_stall  = !cw.wait_req;
   assign req_accept = req_valid && !req_stall;
   assign finish_go  = cw.finish && !(rsp_valid_ff && rsp_stall);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_out_ff;

   // coefficients that need no multiply
   assign opd       = {1'b1, pole_ff};
   assign gain_wide = ((GW'(opd) + GW'(G_RND)) >> G_RS) << G_LS;
   assign a2_wide   = ((GW'(pole_ff) + GW'(D_RND)) >> D_RS) << D_LS;
   assign gain      = COEF_W'(gain_wide);
   assign a2        = COEF_W'(a2_wide);

   always_comb begin
      case (cw.mul_a)
         bqn_pkg::MA_OPD:  mul_a = MA_W'(opd);
         bqn_pkg::MA_GAIN: mul_a = MA_W'(gain);
         bqn_pkg::MA_A1:   mul_a = MA_W'(a1_ff);
         bqn_pkg::MA_A2:   mul_a = MA_W'(a2);
         default:          mul_a = MA_W'(opd);
      endcase
      case (cw.mul_b)
         bqn_pkg::MB_COS: mul_b = MB_W'(cos_ff);
         bqn_pkg::MB_X0:  mul_b = MB_W'(x0_ff);
         bqn_pkg::MB_X1:  mul_b = MB_W'(x1_ff);
         bqn_pkg::MB_X2:  mul_b = MB_W'(x2_ff);
         bqn_pkg::MB_Y1:  mul_b = MB_W'(y1_ff);
         bqn_pkg::MB_Y2:  mul_b = MB_W'(y2_ff);
         default:         mul_b = MB_W'(cos_ff);
      endcase
   end

   assign prod_in  = PW'(mul_a * mul_b);
   assign a1_sum   = -((PW+1)'(prod_ff)) + A1_RND;
   assign a1_shift = a1_sum >>> A1_RS;
   assign a1_in    = cw.load_a1 ? COEF_W'(a1_shift) : a1_ff;

   always_comb begin
      case (cw.acc_op)
         bqn_pkg::ACC_HOLD: acc_in = acc_ff;
         bqn_pkg::ACC_LOAD: acc_in = ACC_W'(prod_ff);
         bqn_pkg::ACC_ADD:  acc_in = acc_ff + ACC_W'(prod_ff);
         bqn_pkg::ACC_SUB:  acc_in = acc_ff - ACC_W'(prod_ff);
         default:           acc_in = acc_ff;
      endcase
   end

   // round half up, then saturate
   assign y_sum  = (ACC_W+1)'(acc_ff) + Y_RND;
   assign y_full = y_sum >>> F;
   always_comb begin
      if (y_full > Y_MAX) begin
         y_sat = S'(Y_MAX);
      end else if (y_full < Y_MIN) begin
         y_sat = S'(Y_MIN);
      end else begin
         y_sat = S'(y_full);
      end
   end

   always_comb begin
      cos_in  = cos_ff;
      pole_in = pole_ff;
      if (csr_wr_en) begin
         case (csr_index)
            bqn_pkg::CSR_NOTCH_COS: cos_in  = csr_wr_data;
            bqn_pkg::CSR_POLE_D:    pole_in = csr_wr_data[bqn_pkg::POLE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      step_in = step_ff + bqn_pkg::STEP_W'(1);
      if (cw.wait_req) begin
         step_in = req_accept ? bqn_pkg::STEP_W'(1) : step_ff;
      end else if (cw.finish) begin
         step_in = finish_go ? bqn_pkg::STEP_W'(0) : step_ff;
      end
   end

   assign x0_in      = req_accept ? req_sample_in : x0_ff;
   assign x1_in      = finish_go ? x0_ff : x1_ff;
   assign x2_in      = finish_go ? x1_ff : x2_ff;
   assign y1_in      = finish_go ? y_sat : y1_ff;
   assign y2_in      = finish_go ? y1_ff : y2_ff;
   assign rsp_out_in = finish_go ? y_sat : rsp_out_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish_go) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff       <= bqn_pkg::NOTCH_COS_RST;
         pole_ff      <= bqn_pkg::POLE_D_RST;
         step_ff      <= '0;
         x1_ff        <= '0;
         x2_ff        <= '0;
         y1_ff        <= '0;
         y2_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cos_ff       <= cos_in;
         pole_ff      <= pole_in;
         step_ff      <= step_in;
         x1_ff        <= x1_in;
         x2_ff        <= x2_in;
         y1_ff        <= y1_in;
         y2_ff        <= y2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff      <= x0_in;
      a1_ff      <= a1_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      rsp_out_ff <= rsp_out_in;
   end

endmodule

`default_nettype wire

FILE: sv/bqn_checker.sv
// Port-level checker for the biquad notch filter core, with its bind statement.
`timescale 1ns / 1ps
`default_nettype none

module bqn_checker #(
   parameter int SAMPLE_BITS = bqn_pkg::SAMPLE_BITS_DEF
) (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_stall,
   input wire                          rsp_valid,
   input wire                          rsp_stall,
   input wire signed [SAMPLE_BITS-1:0] rsp_sample_out
);

   logic req_accept;
   assign req_accept = req_valid && !req_stall;

   // hold the request side closed for the whole program
   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall ##1 req_stall ##1 req_stall ##1 req_stall
                     ##1 req_stall ##1 req_stall ##1 req_stall)
      else $error("request taken before the program finished");

   // a fresh result follows a request once the whole program has run
   a_result_has_request: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_accept, 8))
      else $error("result appeared without a matching request");

   // no result may be invented early in a program
   a_no_result_while_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept ##1 (!rsp_valid || !rsp_stall) |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_out))
      else $error("stalled result changed");

endmodule

bind biquad_notch_filter_core bqn_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_bqn_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_sample_out (rsp_sample_out)
);

`default_nettype wire

FILE: tb/sv/biquad_notch_filter_core_test.sv
// Self-checking testbench for the biquad notch filter core, with its own fixed-point predictor.
`timescale 1ns / 1ps

class notch_scoreboard;
   localparam int SB   = bqn_pkg::SAMPLE_BITS_DEF;
   localparam int FRAC = bqn_pkg::COEF_FRAC_BITS_DEF;
   localparam longint OUT_MAX = (longint'(1) <<< (SB - 1)) - 1;
   localparam longint OUT_MIN = -OUT_MAX - 1;

   logic signed [bqn_pkg::COS_W-1:0] cos_setting;
   logic        [bqn_pkg::POLE_W-1:0] pole_setting;
   logic signed [SB-1:0] prev_inputs[2];
   logic signed [SB-1:0] prev_outputs[2];
   logic signed [SB-1:0] expected_samples[$];
   int mismatches;
   int requests_noted;
   int results_checked;
   int clipped;

   function new();
      cos_setting     = bqn_pkg::NOTCH_COS_RST;
      pole_setting    = bqn_pkg::POLE_D_RST;
      prev_inputs     = '{default: '0};
      prev_outputs    = '{default: '0};
      mismatches      = 0;
      requests_noted  = 0;
      results_checked = 0;
      clipped         = 0;
   endfunction

   function void write_register(input logic [bqn_pkg::CSR_IDX_W-1:0] idx,
                                input logic [bqn_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         bqn_pkg::CSR_NOTCH_COS: begin
            cos_setting = data;
         end
         bqn_pkg::CSR_POLE_D: begin
            pole_setting = data[bqn_pkg::POLE_W-1:0];
         end
         default: begin
         end
      endcase
   endfunction

   function logic signed [SB-1:0] filter_sample(input logic signed [SB-1:0] x);
      longint c;
      longint opd;
      longint gain;
      longint a1;
      longint a2;
      longint acc;
      longint y;
      c    = cos_setting;
      opd  = 32768 + longint'(pole_setting);
      // round each coefficient half up to FRAC fractional bits
      gain = (opd + (longint'(1) <<< (15 - FRAC))) >>> (16 - FRAC);
      a1   = (-(opd * c) + (longint'(1) <<< (28 - FRAC))) >>> (29 - FRAC);
      a2   = (longint'(pole_setting) + (longint'(1) <<< (14 - FRAC))) >>> (15 - FRAC);
      acc  = gain * x + a1 * prev_inputs[0] + gain * prev_inputs[1]
             - a1 * prev_outputs[0] - a2 * prev_outputs[1];
      y    = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
      if (y > OUT_MAX || y < OUT_MIN) begin
         clipped++;
         y = (y > OUT_MAX) ? OUT_MAX : OUT_MIN;
      end
      prev_inputs[1]  = prev_inputs[0];
      prev_inputs[0]  = x;
      prev_outputs[1] = prev_outputs[0];
      prev_outputs[0] = SB'(y);
      return SB'(y);
   endfunction

   function void note_request(input logic signed [SB-1:0] x);
      requests_noted++;
      expected_samples.push_back(filter_sample(x));
   endfunction

   function void check_result(input logic signed [SB-1:0] y);
      logic signed [SB-1:0] want;
      results_checked++;
      if (expected_samples.size() == 0) begin
         $error("sample_out: expected nothing, actual %0d", y);
         mismatches++;
      end else begin
         want = expected_samples.pop_front();
         if (y !== want) begin
            $error("sample_out: expected %0d, actual %0d", want, y);
            mismatches++;
         end
      end
   endfunction
endclass

module biquad_notch_filter_core_test;

   localparam int SB         = bqn_pkg::SAMPLE_BITS_DEF;
   localparam int PHASES     = 8;
   localparam int PHASE_ITEMS = 250;
   localparam int IDLE_LIMIT = 2000;

   localparam logic [bqn_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = bqn_pkg::CSR_IDX_W'(2);
   localparam logic [bqn_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = bqn_pkg::CSR_IDX_W'(3);

   localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB - 1){1'b1}}};
   localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB - 1){1'b0}}};

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_wr_en = 1'b0;
   logic [bqn_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [bqn_pkg::CSR_DATA_W-1:0] csr_wr_data = '0;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic signed [SB-1:0]           req_sample_in = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic signed [SB-1:0]           rsp_sample_out;

   notch_scoreboard sb;
   logic steady = 1'b0;
   int   settings_used = 0;
   int   idle_cycles = 0;

   biquad_notch_filter_core uut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && !steady && ($urandom_range(99) < 15);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_request(req_sample_in);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_sample_out);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Stuck for %0d cycles with %0d results outstanding",
                     idle_cycles, sb.expected_samples.size());
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic write_csr(input logic [bqn_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bqn_pkg::CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      sb.write_register(idx, data);
   endtask

   task automatic apply_setting(input logic signed [bqn_pkg::COS_W-1:0] cos_val,
                                input logic [bqn_pkg::POLE_W-1:0] pole_val);
      logic [bqn_pkg::CSR_DATA_W-1:0] junk;
      junk = bqn_pkg::CSR_DATA_W'($urandom);
      write_csr(CSR_SPARE_LO, junk);
      write_csr(bqn_pkg::CSR_NOTCH_COS, cos_val);
      // set the unused top bit at random: it must be dropped
      write_csr(bqn_pkg::CSR_POLE_D, {junk[bqn_pkg::CSR_DATA_W-1], pole_val});
      write_csr(CSR_SPARE_HI, ~junk);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   task automatic send_sample(input logic signed [SB-1:0] x);
      while (!steady && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= x;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_samples.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [SB-1:0] random_sample();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) begin
         return SB'($urandom);
      end else if (pick < 85) begin
         return SB'(int'($urandom_range(511)) - 256);
      end else begin
         return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
      end
   endfunction

   initial begin
      logic signed [SB-1:0]             first_run[12];
      logic signed [SB-1:0]             second_run[11];
      logic signed [bqn_pkg::COS_W-1:0] cos_val;
      logic [bqn_pkg::POLE_W-1:0]       pole_val;
      sb = new();
      first_run  = '{'0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, 16'sd1, -16'sd1,
                     16'sd16384, -16'sd16384, 16'sh5555, 16'shAAAA, '0};
      second_run = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN,
                     SAMPLE_MIN, SAMPLE_MIN, '0, 16'sd12345, -16'sd1};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset coefficients first, then a cosine beyond -1 with the widest pole
      foreach (first_run[i]) send_sample(first_run[i]);
      drain_results();
      apply_setting(SAMPLE_MIN, {bqn_pkg::POLE_W{1'b1}});
      foreach (second_run[i]) send_sample(second_run[i]);
      drain_results();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               cos_val  = 16'sd16384;
               pole_val = {bqn_pkg::POLE_W{1'b1}};
            end
            1: begin
               cos_val  = -16'sd16384;
               pole_val = '0;
            end
            2: begin
               cos_val  = '0;
               pole_val = bqn_pkg::POLE_W'($urandom);
            end
            4: begin
               cos_val  = SAMPLE_MIN;
               pole_val = {bqn_pkg::POLE_W{1'b1}};
            end
            5: begin
               cos_val  = SAMPLE_MAX;
               pole_val = bqn_pkg::POLE_W'($urandom);
            end
            7: begin
               cos_val  = bqn_pkg::NOTCH_COS_RST;
               pole_val = bqn_pkg::POLE_D_RST;
            end
            default: begin
               cos_val  = bqn_pkg::COS_W'(int'($urandom_range(32768)) - 16384);
               pole_val = bqn_pkg::POLE_W'($urandom);
            end
         endcase
         apply_setting(cos_val, pole_val);
         steady = (phase == 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 5 && n == PHASE_ITEMS / 2) begin
               drain_results();
            end
            send_sample(random_sample());
         end
         drain_results();
         steady = 1'b0;
      end

      repeat (2 * bqn_pkg::PROG_STEPS) @(posedge clock);
      $display("Filtered %0d requests under %0d coefficient settings; %0d outputs clipped.",
               sb.requests_noted, settings_used + 1, sb.clipped);
      $display("Checked %0d results, %0d mismatches.", sb.results_checked, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

FILE: files.f
sv/bqn_pkg.sv
sv/biquad_notch_filter_core.sv
sv/bqn_checker.sv
tb/sv/biquad_notch_filter_core_test.sv
